// ===== hdl/triangle_primitive_assembly_defines.svh =====
// Assertion macros for the triangle primitive assembly block.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLY_DEFINES_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLY_DEFINES_SVH

`ifndef SYNTH
// Check a property outside of reset.
`define TPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPA_ASSERT(label, prop, msg)
`define TPA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/tpa_pkg.sv =====
// Shared types and constants for the triangle primitive assembly block.
package tpa_pkg;

  localparam int CORNER_BITS    = 32;
  localparam int VCOUNT_BITS    = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRIMITIVE_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT   = 2'd1;

  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_STRIP = 2'd1,
    MODE_FAN   = 2'd2,
    MODE_NONE  = 2'd3
  } prim_mode_t;

  typedef struct packed {
    logic [CORNER_BITS-1:0] corner_a;
    logic [CORNER_BITS-1:0] corner_b;
    logic [CORNER_BITS-1:0] corner_c;
    logic                   last;
  } triangle_t;

endpackage

// ===== hdl/tpa_assemble.sv =====
// Assembly state and triangle selection for one index beat.
module tpa_assemble import tpa_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [INDEX_BITS-1:0]  vertex,
  input  logic                   last,
  input  prim_mode_t             mode,
  input  logic [VCOUNT_BITS-1:0] vertex_count,
  output logic                   emit,
  output triangle_t              tri_out
);

  logic [INDEX_BITS-1:0] fan_anchor_r, fan_anchor_nxt;
  logic [INDEX_BITS-1:0] older_index_r, older_index_nxt;
  logic [INDEX_BITS-1:0] newer_index_r, newer_index_nxt;
  logic [1:0]            seen_count_r, seen_count_nxt;
  logic                  odd_position_r, odd_position_nxt;
  logic [1:0]            list_phase_r, list_phase_nxt;

  logic [INDEX_BITS-1:0] raw_a, raw_b;
  logic [CORNER_BITS-1:0] wide_a, wide_b, wide_c;

  // Pick the two older corners by mode
  always_comb begin
    emit  = 1'b0;
    raw_a = '0;
    raw_b = '0;
    case (mode)
      MODE_LIST: begin
        if (list_phase_r == 2'd2) begin
          emit  = 1'b1;
          raw_a = older_index_r;
          raw_b = newer_index_r;
        end
      end
      MODE_STRIP: begin
        if (seen_count_r == 2'd2) begin
          emit = 1'b1;
          if (odd_position_r) begin
            raw_a = newer_index_r;
            raw_b = older_index_r;
          end else begin
            raw_a = older_index_r;
            raw_b = newer_index_r;
          end
        end
      end
      MODE_FAN: begin
        if (seen_count_r == 2'd2) begin
          emit  = 1'b1;
          raw_a = fan_anchor_r;
          raw_b = newer_index_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Clamp out-of-range corners to zero
  assign wide_a = CORNER_BITS'(raw_a);
  assign wide_b = CORNER_BITS'(raw_b);
  assign wide_c = CORNER_BITS'(vertex);

  always_comb begin
    tri_out.corner_a = (wide_a >= vertex_count) ? '0 : wide_a;
    tri_out.corner_b = (wide_b >= vertex_count) ? '0 : wide_b;
    tri_out.corner_c = (wide_c >= vertex_count) ? '0 : wide_c;
    tri_out.last     = last;
  end

  // Advance the history, or drop it at the end of a primitive
  always_comb begin
    if (last) begin
      fan_anchor_nxt   = '0;
      older_index_nxt  = '0;
      newer_index_nxt  = '0;
      seen_count_nxt   = 2'd0;
      odd_position_nxt = 1'b0;
      list_phase_nxt   = 2'd0;
    end else begin
      fan_anchor_nxt   = (seen_count_r == 2'd0) ? vertex : fan_anchor_r;
      older_index_nxt  = newer_index_r;
      newer_index_nxt  = vertex;
      seen_count_nxt   = (seen_count_r == 2'd2) ? 2'd2 : seen_count_r + 2'd1;
      odd_position_nxt = ~odd_position_r;
      list_phase_nxt   = (list_phase_r >= 2'd2) ? 2'd0 : list_phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_anchor_r   <= '0;
      older_index_r  <= '0;
      newer_index_r  <= '0;
      seen_count_r   <= 2'd0;
      odd_position_r <= 1'b0;
      list_phase_r   <= 2'd0;
    end else if (step_en) begin
      fan_anchor_r   <= fan_anchor_nxt;
      older_index_r  <= older_index_nxt;
      newer_index_r  <= newer_index_nxt;
      seen_count_r   <= seen_count_nxt;
      odd_position_r <= odd_position_nxt;
      list_phase_r   <= list_phase_nxt;
    end
  end

endmodule

// ===== hdl/triangle_primitive_assembly.sv =====
// Triangle primitive assembly: list, strip and fan index streams to triangles.
// Path: an accepted index beat goes to the input register, then assembly loads it
// into the result register; a stalled result holds the beat in the input register.
// Throughput: one index beat per cycle while no stalled result blocks the input,
// set by the single-step assembly state. Reset (synchronous, active low) clears both
// stages, the history and the configuration (list mode, vertex count zero).
`include "triangle_primitive_assembly_defines.svh"

module triangle_primitive_assembly import tpa_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write port
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // index channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_vertex_index,
  input  logic                      in_primitive_last,
  // triangle channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CORNER_BITS-1:0]    out_corner_a,
  output logic [CORNER_BITS-1:0]    out_corner_b,
  output logic [CORNER_BITS-1:0]    out_corner_c,
  output logic                      out_triangle_last
);

  prim_mode_t             mode_r;
  logic [VCOUNT_BITS-1:0] vertex_count_r;

  logic                  s1_valid_r;
  logic [INDEX_BITS-1:0] s1_vertex_r;
  logic                  s1_last_r;
  logic                  s1_fire;
  logic                  in_accept;

  logic                  out_valid_r;
  triangle_t             out_tri_r;

  logic                  emit;
  triangle_t             tri_nxt;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_LIST;
      vertex_count_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRIMITIVE_MODE: mode_r         <= prim_mode_t'(cfg_wdata[1:0]);
        CFG_VERTEX_COUNT:   vertex_count_r <= cfg_wdata[VCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage when the result register can take its beat
  assign s1_fire   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_vertex_r <= in_vertex_index[INDEX_BITS-1:0];
      s1_last_r   <= in_primitive_last;
    end
  end

  tpa_assemble #(
    .INDEX_BITS (INDEX_BITS)
  ) u_assemble (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_fire),
    .vertex       (s1_vertex_r),
    .last         (s1_last_r),
    .mode         (mode_r),
    .vertex_count (vertex_count_r),
    .emit         (emit),
    .tri_out      (tri_nxt)
  );

  // Load the result register, or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_tri_r <= tri_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_a      = out_tri_r.corner_a;
  assign out_corner_b      = out_tri_r.corner_b;
  assign out_corner_c      = out_tri_r.corner_c;
  assign out_triangle_last = out_tri_r.last;

  // Checks
  `TPA_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "result valid after reset")
  `TPA_ASSERT(a_emit_shows, (s1_fire && emit) |=> out_valid_r, "emitted triangle not shown")
  `TPA_ASSERT(a_stall_cause, in_stall |-> (s1_valid_r && out_valid_r && out_stall), "stall without a blocked result")
  `TPA_ASSERT(a_idle_drop, (s1_fire && !emit) |=> !out_valid_r, "result without emit")

endmodule

// ===== tb/sv/tpa_triangle_checker.sv =====
// Checker for the triangle primitive assembly block: predicts and compares triangles.
module tpa_triangle_checker import tpa_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [31:0]               in_vertex_index,
  input  logic                      in_primitive_last,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [CORNER_BITS-1:0]    out_corner_a,
  input  logic [CORNER_BITS-1:0]    out_corner_b,
  input  logic [CORNER_BITS-1:0]    out_corner_c,
  input  logic                      out_triangle_last,
  output int                        mismatch_count,
  output int                        pending_triangles
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] INDEX_MASK = 32'hFFFF_FFFF >> (32 - INDEX_BITS);

  // Shadow copy of the configuration registers
  prim_mode_t  mode_reg   = MODE_LIST;
  logic [31:0] vcount_reg = '0;

  // Index history of the primitive in progress
  logic [31:0] first_idx  = '0;
  logic [31:0] prev2_idx  = '0;
  logic [31:0] prev_idx   = '0;
  logic [1:0]  seen_idx   = '0;
  logic        odd_pos    = 1'b0;
  logic [1:0]  group_pos  = '0;

  triangle_t expected_triangles[$];
  int        fails  = 0;
  int        queued = 0;

  assign mismatch_count    = fails;
  assign pending_triangles = queued;

  // Replace a corner outside the vertex range by zero
  function automatic logic [31:0] clamp_to_range(input logic [31:0] v);
    return (v >= vcount_reg) ? '0 : v;
  endfunction

  task automatic clear_history();
    first_idx = '0;
    prev2_idx = '0;
    prev_idx  = '0;
    seen_idx  = '0;
    odd_pos   = 1'b0;
    group_pos = '0;
  endtask

  // Append a predicted triangle behind the older ones
  task automatic enqueue_prediction(input triangle_t t);
    expected_triangles.insert(expected_triangles.size(), t);
  endtask

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t ns: %s", $realtime, what);
  endtask

  // Advance the history by one index beat and return the triangle it closes, if any
  task automatic assemble_index(input logic [31:0] raw, input logic last,
                                output bit emit, output triangle_t closed);
    logic [31:0] v;
    logic [31:0] a;
    logic [31:0] b;
    v    = raw & INDEX_MASK;
    emit = 1'b0;
    a    = '0;
    b    = '0;
    case (mode_reg)
      MODE_LIST: begin
        if (group_pos == 2'd2) begin
          emit = 1'b1;
          a    = prev2_idx;
          b    = prev_idx;
        end
      end
      MODE_STRIP: begin
        // odd positions swap the first two corners to keep the winding
        if (seen_idx == 2'd2) begin
          emit = 1'b1;
          a    = odd_pos ? prev_idx : prev2_idx;
          b    = odd_pos ? prev2_idx : prev_idx;
        end
      end
      MODE_FAN: begin
        if (seen_idx == 2'd2) begin
          emit = 1'b1;
          a    = first_idx;
          b    = prev_idx;
        end
      end
      default: ;
    endcase
    // the history moves the same way in every mode
    if (last) begin
      clear_history();
    end else begin
      if (seen_idx == 2'd0) first_idx = v;
      prev2_idx = prev_idx;
      prev_idx  = v;
      if (seen_idx != 2'd2) seen_idx = seen_idx + 2'd1;
      odd_pos   = ~odd_pos;
      group_pos = (group_pos == 2'd2) ? 2'd0 : group_pos + 2'd1;
    end
    closed = '{corner_a: clamp_to_range(a), corner_b: clamp_to_range(b),
               corner_c: clamp_to_range(v), last: last};
  endtask

  always @(posedge clk) begin : watch
    bit        emit;
    triangle_t predicted;
    triangle_t want;
    if (!rst_n) begin
      mode_reg   = MODE_LIST;
      vcount_reg = '0;
      clear_history();
      expected_triangles.delete();
    end else begin
      // track register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_PRIMITIVE_MODE) mode_reg = prim_mode_t'(cfg_wdata[1:0]);
        else if (cfg_index == CFG_VERTEX_COUNT) vcount_reg = cfg_wdata;
      end
      // predict from each accepted index beat
      if (in_valid && !in_stall) begin
        assemble_index(in_vertex_index, in_primitive_last, emit, predicted);
        if (emit) enqueue_prediction(predicted);
      end
      // compare each accepted triangle beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_triangles.size() == 0) begin
          report_mismatch($sformatf("unexpected triangle %h %h %h last %b",
                                    out_corner_a, out_corner_b, out_corner_c,
                                    out_triangle_last));
        end else begin
          want = expected_triangles.pop_front();
          if (out_corner_a !== want.corner_a)
            report_mismatch($sformatf("corner_a %h, expected %h", out_corner_a, want.corner_a));
          if (out_corner_b !== want.corner_b)
            report_mismatch($sformatf("corner_b %h, expected %h", out_corner_b, want.corner_b));
          if (out_corner_c !== want.corner_c)
            report_mismatch($sformatf("corner_c %h, expected %h", out_corner_c, want.corner_c));
          if (out_triangle_last !== want.last)
            report_mismatch($sformatf("triangle_last %b, expected %b",
                                      out_triangle_last, want.last));
        end
      end
    end
    queued = expected_triangles.size();
  end

endmodule

// ===== tb/sv/tb_triangle_primitive_assembly.sv =====
// Testbench top for the triangle primitive assembly block: stimulus and verdict.
module tb_triangle_primitive_assembly;
  timeunit 1ns;
  timeprecision 1ps;
  import tpa_pkg::*;

  localparam int INDEX_BITS      = 32;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 75;

  logic                      clk               = 1'b0;
  logic                      rst_n             = 1'b0;
  logic                      cfg_wr_en         = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index         = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata         = '0;
  logic                      in_valid          = 1'b0;
  logic                      in_stall;
  logic [31:0]               in_vertex_index   = '0;
  logic                      in_primitive_last = 1'b0;
  logic                      out_valid;
  logic                      out_stall         = 1'b0;
  logic [CORNER_BITS-1:0]    out_corner_a;
  logic [CORNER_BITS-1:0]    out_corner_b;
  logic [CORNER_BITS-1:0]    out_corner_c;
  logic                      out_triangle_last;

  int mismatch_count;
  int pending_triangles;
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit long_holds = 1'b0;
  int hold_left  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_primitive_assembly #(.INDEX_BITS(INDEX_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_vertex_index   (in_vertex_index),
    .in_primitive_last (in_primitive_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_corner_a      (out_corner_a),
    .out_corner_b      (out_corner_b),
    .out_corner_c      (out_corner_c),
    .out_triangle_last (out_triangle_last)
  );

  tpa_triangle_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_vertex_index   (in_vertex_index),
    .in_primitive_last (in_primitive_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_corner_a      (out_corner_a),
    .out_corner_b      (out_corner_b),
    .out_corner_c      (out_corner_c),
    .out_triangle_last (out_triangle_last),
    .mismatch_count    (mismatch_count),
    .pending_triangles (pending_triangles)
  );

  // Triangle receiver: random stalls, plus long hold-offs during the pressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds && $urandom_range(15) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(80, 40);
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one index beat after a random gap and hold it until accepted
  task automatic send_index(input logic [31:0] v, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_vertex_index   <= v;
    in_primitive_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted triangle, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_triangles != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Favor small indices and values around the vertex count bound
  function automatic logic [31:0] pick_index(input logic [31:0] bound);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(47);
      4, 5:       return bound + 32'($urandom_range(2)) - 32'd1;
      6:          return ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    int          sent;
    int          len;
    int          p;
    int          k;
    bit          noisy;
    logic [31:0] vc;
    prim_mode_t  mode;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // List: one full group with both index extremes, then a partial group closed by last
    write_reg(CFG_VERTEX_COUNT, 32'hFFFF_FFFF);
    send_index(32'h0, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b0);
    send_index(32'hFFFF_FFFE, 1'b0);
    send_index(32'd5, 1'b0);
    send_index(32'd6, 1'b1);
    settle();

    // Strip: alternating winding, then a one-index primitive that emits nothing
    write_reg(CFG_PRIMITIVE_MODE, 32'(MODE_STRIP));
    for (k = 1; k <= 5; k++) send_index(k, k == 5);
    send_index(32'd9, 1'b1);
    settle();

    // Fan with a small vertex count so that some corners clamp to zero
    write_reg(CFG_PRIMITIVE_MODE, 32'(MODE_FAN));
    write_reg(CFG_VERTEX_COUNT, 32'd4);
    send_index(32'd7, 1'b0);
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd3, 1'b1);
    settle();

    // Silent mode still tracks indices; switch to fan inside the primitive
    write_reg(CFG_PRIMITIVE_MODE, 32'(MODE_NONE));
    write_reg(CFG_VERTEX_COUNT, 32'd100);
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd3, 1'b0);
    settle();
    write_reg(CFG_PRIMITIVE_MODE, 32'(MODE_FAN));
    send_index(32'd4, 1'b0);
    send_index(32'd5, 1'b1);
    settle();

    // Zero vertex count: every corner comes out as zero
    write_reg(CFG_PRIMITIVE_MODE, 32'(MODE_LIST));
    write_reg(CFG_VERTEX_COUNT, 32'd0);
    send_index(32'd9, 1'b0);
    send_index(32'd8, 1'b0);
    send_index(32'd7, 1'b1);
    settle();

    // Random phases: every mode against each vertex count class and idling profile
    for (p = 0; p < PHASES; p++) begin
      mode = prim_mode_t'(2'(p % 4));
      case (p / 4)
        0:       vc = 32'hFFFF_FFFF;
        1:       vc = $urandom_range(40, 1);
        2:       vc = '0;
        default: vc = $urandom;
      endcase
      write_reg(CFG_PRIMITIVE_MODE, 32'(mode));
      write_reg(CFG_VERTEX_COUNT, vc);
      case ((p + p / 4) % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 86; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      // pressure phase: steady sender against long receiver hold-offs
      long_holds = (p == 5);
      if (long_holds) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len   = $urandom_range(12, 1);
        noisy = ($urandom_range(9) == 0);
        for (k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
          send_index(pick_index(vc), noisy ? ($urandom_range(3) == 0) : (k == len - 1));
          sent++;
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("triangle_primitive_assembly: match");
    end else begin
      $display("triangle_primitive_assembly: mismatch");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #400_000;
    $display("triangle_primitive_assembly: mismatch");
    $finish;
  end

endmodule
